@@ rtl/keyed_threat_table_with_aging_unit_macros.svh @@
// Assertion macros shared by the keyed threat table RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef KEYED_THREAT_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define KEYED_THREAT_TABLE_WITH_AGING_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ktt_pkg.sv @@
// Package for the keyed threat table: field widths, codes and the table entry type.
// No dependencies; used by ktt_ram and keyed_threat_table_with_aging_unit.
package ktt_pkg;

	localparam int KEY_W     = 32;
	localparam int TIME_W    = 32;
	localparam int LVL_W     = 4;
	localparam int ST_W      = 2;
	localparam int OP_W      = 2;
	localparam int CNT_OUT_W = 6;
	localparam int TMO_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	localparam int S_DATA_W  = 104;
	localparam int M_FIELD_W = ST_W + LVL_W + CNT_OUT_W;
	localparam int M_DATA_W  = 16;
	localparam int M_PAD_W   = M_DATA_W - M_FIELD_W;

	localparam logic [OP_W-1:0] OP_ALERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_PURGE  = 2'd1;
	localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

	localparam logic [ST_W-1:0] ST_SAME    = 2'd0;
	localparam logic [ST_W-1:0] ST_CHANGED = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
	localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

	localparam logic [TMO_W-1:0]     TMO_RESET = 16'd5000;
	localparam logic [CNT_OUT_W-1:0] CNT_MAX   = '1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [LVL_W-1:0]  lvl;
		logic [TIME_W-1:0] stamp;
	} entry_t;

endpackage

@@ rtl/keyed_threat_table_with_aging_unit.sv @@
// An alert is accepted, scans every entry of both tables, takes an update step and then
// sends one result for each level from 1 up to the top level on a change, a single one else.
// Purge and report take the same scan without the update step; a report always sends the
// per-level results. One item is in work at a time; ignored alerts skip the scan.
// Reset clears all valid bits and the registers; no clearing pass is needed.
`include "keyed_threat_table_with_aging_unit_macros.svh"

module keyed_threat_table_with_aging_unit
	import ktt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int LEVELS = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// responder_id, oncoming_id, threat_level, time_now, zero fill
	input  logic [S_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// status, level, count, zero fill
	output logic [M_DATA_W-1:0]  m_tdata,
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int N_ENT = 2 * TABLE_DEPTH;
	localparam int AW = $clog2(N_ENT);
	localparam int CW = $clog2(N_ENT + 1);
	localparam int CXW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
	localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS - 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_EMIT} state_t;
	typedef enum logic [1:0] {MD_ALERT, MD_PURGE, MD_REPORT} mode_t;

	state_t state_q;
	mode_t mode_q;
	logic tgt_q;
	logic multi_q;
	logic [KEY_W-1:0] key_q;
	logic [LVL_W-1:0] lvl_q;
	logic [TIME_W-1:0] now_q;
	logic [ST_W-1:0] st_q;
	logic [AW:0] sc_q;
	logic rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;
	logic hit_q;
	logic [AW-1:0] hit_slot_q;
	logic [LVL_W-1:0] hit_lvl_q;
	logic free_q;
	logic [AW-1:0] free_slot_q;
	logic chg_q;
	logic [LVL_W-1:0] lv_q;
	logic [N_ENT-1:0] vld_q;
	logic [CW-1:0] cnt_q [LEVELS];
	logic m_tvalid_q;
	logic m_tlast_q;
	logic [ST_W-1:0] m_st_q;
	logic [LVL_W-1:0] m_lvl_q;
	logic [CNT_OUT_W-1:0] m_cnt_q;
	logic [KEY_W-1:0] own_id_q;
	logic [TMO_W-1:0] timeout_q;

	logic [OP_W-1:0] in_op;
	logic [KEY_W-1:0] in_rid;
	logic [KEY_W-1:0] in_key;
	logic [LVL_W-1:0] in_lvl;
	logic [TIME_W-1:0] in_now;
	logic is_own;
	logic is_bc;
	logic accept;

	entry_t rdata;
	entry_t wdata;
	logic rd_en;
	logic sc_act;
	logic e_vld;
	logic e_tbl;
	logic [TIME_W-1:0] age;
	logic stale;
	logic drop;
	logic hit_now;
	logic free_now;
	logic chg_now;
	logic scan_done;
	logic [LEVELS-1:0] scan_inc;

	logic ap_we;
	logic ap_set;
	logic ap_clr;
	logic [AW-1:0] ap_slot;
	logic [ST_W-1:0] ap_st;
	logic ap_inc_en;
	logic ap_dec_en;
	logic [LEVELS-1:0] ap_inc;
	logic [LEVELS-1:0] ap_dec;

	logic [CW-1:0] sel_cnt;
	logic [CXW-1:0] sel_ext;
	logic [CNT_OUT_W-1:0] sat_cnt;

	assign in_op = s_tuser;
	assign in_rid = s_tdata[31:0];
	assign in_key = s_tdata[63:32];
	assign in_lvl = s_tdata[67:64];
	assign in_now = s_tdata[99:68];
	assign is_own = (in_rid == own_id_q);
	assign is_bc = (in_rid == '0);
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = m_tvalid_q;
	assign m_tlast = m_tlast_q;
	assign m_tdata = {{M_PAD_W{1'b0}}, m_cnt_q, m_lvl_q, m_st_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			timeout_q <= TMO_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OWN_ID: own_id_q <= cfg_data;
				REG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	assign rd_en = (state_q == S_SCAN) && (sc_q < (AW+1)'(N_ENT));
	assign wdata = '{key: key_q, lvl: lvl_q, stamp: now_q};

	ktt_ram #(
		.DEPTH(N_ENT)
	) u_ram (
		.clk(clk),
		.we(ap_we),
		.waddr(ap_slot),
		.wdata(wdata),
		.re(rd_en),
		.raddr(sc_q[AW-1:0]),
		.rdata(rdata)
	);

	// One entry per cycle: key match and age compare on the entry read last cycle.
	assign sc_act = (state_q == S_SCAN) && rd_vld_s1;
	assign e_vld = vld_q[rd_addr_s1];
	assign e_tbl = (rd_addr_s1 >= AW'(TABLE_DEPTH));
	assign age = now_q - rdata.stamp;
	assign stale = (age >= TIME_W'(timeout_q));
	assign drop = sc_act && (mode_q == MD_PURGE) && e_vld && stale;
	assign hit_now = sc_act && (mode_q == MD_ALERT) && (e_tbl == tgt_q) && e_vld
		&& (rdata.key == key_q) && !hit_q;
	assign free_now = sc_act && (mode_q == MD_ALERT) && (e_tbl == tgt_q) && !e_vld && !free_q;
	assign chg_now = drop && (rdata.lvl != '0);
	assign scan_done = sc_act && (sc_q == (AW+1)'(N_ENT));

	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			scan_inc[l] = sc_act && e_vld && !drop && (rdata.lvl == LVL_W'(l));
		end
	end

	always_comb begin
		ap_we = 1'b0;
		ap_set = 1'b0;
		ap_clr = 1'b0;
		ap_slot = hit_slot_q;
		ap_st = ST_SAME;
		ap_inc_en = 1'b0;
		ap_dec_en = 1'b0;
		if (state_q == S_APPLY) begin
			if (!tgt_q) begin
				if (hit_q) begin
					ap_we = 1'b1;
					ap_inc_en = 1'b1;
					ap_dec_en = 1'b1;
					ap_st = (hit_lvl_q != lvl_q) ? ST_CHANGED : ST_SAME;
				end else if (free_q) begin
					ap_we = 1'b1;
					ap_set = 1'b1;
					ap_slot = free_slot_q;
					ap_inc_en = 1'b1;
					ap_st = ST_CHANGED;
				end else begin
					ap_st = ST_FULL;
				end
			end else if (lvl_q == '0) begin
				if (hit_q) begin
					ap_clr = 1'b1;
					ap_dec_en = 1'b1;
					ap_st = ST_CHANGED;
				end
			end else begin
				if (hit_q) begin
					ap_we = 1'b1;
				end else if (free_q) begin
					ap_we = 1'b1;
					ap_set = 1'b1;
					ap_slot = free_slot_q;
					ap_inc_en = 1'b1;
					ap_st = ST_CHANGED;
				end else begin
					ap_st = ST_FULL;
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			ap_inc[l] = ap_inc_en && (lvl_q == LVL_W'(l));
			ap_dec[l] = ap_dec_en && (hit_lvl_q == LVL_W'(l));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				cnt_q[l] <= '0;
			end
		end else begin
			if (drop) begin
				vld_q[rd_addr_s1] <= 1'b0;
			end
			if (ap_set) begin
				vld_q[ap_slot] <= 1'b1;
			end
			if (ap_clr) begin
				vld_q[ap_slot] <= 1'b0;
			end
			for (int l = 0; l < LEVELS; l++) begin
				if (accept) begin
					cnt_q[l] <= '0;
				end else begin
					cnt_q[l] <= cnt_q[l] + CW'(scan_inc[l]) + CW'(ap_inc[l]) - CW'(ap_dec[l]);
				end
			end
		end
	end

	always_comb begin
		sel_cnt = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (lv_q == LVL_W'(l)) begin
				sel_cnt = cnt_q[l];
			end
		end
		sel_ext = CXW'(sel_cnt);
		sat_cnt = (sel_ext > CXW'(CNT_MAX)) ? CNT_MAX : sel_ext[CNT_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MD_ALERT;
			tgt_q <= 1'b0;
			multi_q <= 1'b0;
			key_q <= '0;
			lvl_q <= '0;
			now_q <= '0;
			st_q <= ST_SAME;
			sc_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_addr_s1 <= '0;
			hit_q <= 1'b0;
			hit_slot_q <= '0;
			hit_lvl_q <= '0;
			free_q <= 1'b0;
			free_slot_q <= '0;
			chg_q <= 1'b0;
			lv_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q <= 1'b0;
			m_st_q <= ST_SAME;
			m_lvl_q <= '0;
			m_cnt_q <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						key_q <= in_key;
						lvl_q <= in_lvl;
						now_q <= in_now;
						sc_q <= '0;
						rd_vld_s1 <= 1'b0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						chg_q <= 1'b0;
						lv_q <= LVL_W'(1);
						multi_q <= 1'b0;
						case (in_op)
							OP_ALERT: begin
								if (in_key == '0 && (is_own || is_bc)) begin
									st_q <= ST_IGNORED;
									state_q <= S_EMIT;
								end else if (is_own) begin
									if (in_lvl != '0 && in_lvl != TOP_LVL) begin
										st_q <= ST_IGNORED;
										state_q <= S_EMIT;
									end else begin
										mode_q <= MD_ALERT;
										tgt_q <= 1'b1;
										state_q <= S_SCAN;
									end
								end else if (is_bc) begin
									if (in_lvl >= TOP_LVL) begin
										st_q <= ST_IGNORED;
										state_q <= S_EMIT;
									end else begin
										mode_q <= MD_ALERT;
										tgt_q <= 1'b0;
										state_q <= S_SCAN;
									end
								end else begin
									st_q <= ST_SAME;
									state_q <= S_EMIT;
								end
							end
							OP_PURGE: begin
								mode_q <= MD_PURGE;
								state_q <= S_SCAN;
							end
							OP_REPORT: begin
								mode_q <= MD_REPORT;
								state_q <= S_SCAN;
							end
							default: begin
								st_q <= ST_IGNORED;
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						sc_q <= sc_q + 1'b1;
						rd_vld_s1 <= 1'b1;
						rd_addr_s1 <= sc_q[AW-1:0];
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (hit_now) begin
						hit_q <= 1'b1;
						hit_slot_q <= rd_addr_s1;
						hit_lvl_q <= rdata.lvl;
					end
					if (free_now) begin
						free_q <= 1'b1;
						free_slot_q <= rd_addr_s1;
					end
					if (chg_now) begin
						chg_q <= 1'b1;
					end
					if (scan_done) begin
						case (mode_q)
							MD_ALERT: begin
								state_q <= S_APPLY;
							end
							MD_PURGE: begin
								st_q <= (chg_q || chg_now) ? ST_CHANGED : ST_SAME;
								multi_q <= chg_q || chg_now;
								state_q <= S_EMIT;
							end
							default: begin
								st_q <= ST_SAME;
								multi_q <= 1'b1;
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_APPLY: begin
					st_q <= ap_st;
					multi_q <= (ap_st == ST_CHANGED);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_st_q <= st_q;
						if (multi_q) begin
							m_lvl_q <= lv_q;
							m_cnt_q <= sat_cnt;
							m_tlast_q <= (lv_q == TOP_LVL);
							lv_q <= lv_q + 1'b1;
							if (lv_q == TOP_LVL) begin
								state_q <= S_IDLE;
							end
						end else begin
							m_lvl_q <= '0;
							m_cnt_q <= '0;
							m_tlast_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`KTT_ASSERT_NXT(a_busy_after_accept, accept, !s_tready, "input taken while an item is in work")
	`KTT_ASSERT_IMP(a_last_level, m_tvalid_q && m_tlast_q, m_lvl_q == '0 || m_lvl_q == TOP_LVL, "final result has a wrong level")
	`KTT_ASSERT_IMP(a_no_count_level0, m_tvalid_q && m_lvl_q == '0, m_cnt_q == '0 && m_tlast_q, "result without counts is malformed")
	`KTT_ASSERT_IMP(a_run_status, m_tvalid_q && !m_tlast_q, m_st_q == ST_SAME || m_st_q == ST_CHANGED, "count run carries a wrong status")

endmodule

@@ rtl/ktt_ram.sv @@
// Entry memory for both alert tables, with one write port, one read port and registered read data.
// Depends on ktt_pkg for the entry type.
module ktt_ram
	import ktt_pkg::*;
#(
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
